### hdl/smdf_pkg.sv
// Package for the sliding median filter with output deadband.
// Holds the sequencer states, register codes, reset values and default sizes.
// No dependencies.
`default_nettype none

package smdf_pkg;

  // Default sizes handed to the top level and the sorter.
  localparam int DEF_MAX_WINDOW  = 16;
  localparam int DEF_SAMPLE_BITS = 16;

  // Configuration port geometry.
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 8;
  localparam int WINDOW_SIZE_W = 5;
  localparam int DEADBAND_W    = 8;

  // Register reset values.
  localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RESET = 5'd5;
  localparam logic [DEADBAND_W-1:0]    DEADBAND_RESET    = 8'd0;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_SIZE = 1'b0,
    REG_DEADBAND    = 1'b1
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WARM,
    ST_SHIFT,
    ST_DECIDE
  } state_t;

endpackage

`default_nettype wire

### hdl/smdf_sorter.sv
// Insertion sorter that builds an ascending list one value per cycle.
// Uses smdf_pkg for its default sizes; instantiated by the filter top level.
`default_nettype none

module smdf_sorter #(
  parameter int MAX_WINDOW  = smdf_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = smdf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 clear,
  input  logic                                                 insert,
  input  logic [SAMPLE_BITS-1:0]                               value,
  input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] rank,
  output logic [SAMPLE_BITS-1:0]                               rank_value
);
  import smdf_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  logic [SAMPLE_BITS-1:0] sorted [MAX_WINDOW];
  logic [CNT_W-1:0]       count;
  logic [MAX_WINDOW-1:0]  gt;

  // A slot moves up when it is empty or holds a value above the new one.
  always_comb begin
    for (int k = 0; k < MAX_WINDOW; k++) begin
      gt[k] = (CNT_W'(k) >= count) || (sorted[k] > value);
    end
  end

  // Each slot takes its lower neighbour, the new value, or keeps its own.
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_slot
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (insert && gt[0]) begin
          sorted[0] <= value;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (insert && gt[k]) begin
          sorted[k] <= gt[k-1] ? sorted[k-1] : value;
        end
      end
    end
  end

  // Number of values held in the list.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
    end else if (insert) begin
      count <= count + CNT_W'(1);
    end
  end

  assign rank_value = sorted[rank];

endmodule

`default_nettype wire

### hdl/sliding_median_deadband_filter.sv
// Top level of the sliding median filter with output deadband.
// Depends on smdf_pkg and smdf_sorter; holds the sample window memory.
//
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    sample
//  output    out_valid / out_ready  emitted_value
//  config    cfg_write              cfg_index, cfg_data
//
// A warm-up sample goes from ST_IDLE to ST_WARM, which offers it once the output is free.
// A sample in the shifting phase walks a window of N in ST_SHIFT: the walk moves
// one window entry a cycle from the memory's read port into the sorter, and any result
// is offered from ST_DECIDE once the output is free.
// Reset clears fill count, last emitted value, entry valid bits and presets registers.
// A result still held at the output stalls the sequencer in ST_WARM or ST_DECIDE until it is taken.
`default_nettype none

module sliding_median_deadband_filter #(
  parameter int MAX_WINDOW  = smdf_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = smdf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [SAMPLE_BITS-1:0]             emitted_value,
  input  logic                               cfg_write,
  input  logic [smdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [smdf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import smdf_pkg::*;

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  state_t state, state_next;

  logic [WINDOW_SIZE_W-1:0] window_size;
  logic [DEADBAND_W-1:0]    deadband;
  logic [CNT_W-1:0]         fill_count;
  logic [SAMPLE_BITS-1:0]   last_sent;
  logic [SAMPLE_BITS-1:0]   sample_q;
  logic [CNT_W-1:0]         size_q;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         size_eff;

  // Window memory, its entry valid bits and the registered read port.
  logic [SAMPLE_BITS-1:0]   mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]    entry_valid;
  logic [SAMPLE_BITS-1:0]   rd_data;
  logic                     rd_hit;
  logic                     rd_en;
  logic [CNT_W:0]           rd_addr_full;
  logic [IDX_W-1:0]         rd_addr;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [SAMPLE_BITS-1:0]   mem_wdata;

  logic                     accept;
  logic                     out_free;
  logic                     load_out;
  logic [SAMPLE_BITS-1:0]   out_value;
  logic                     fill_inc;
  logic                     cnt_clear;
  logic                     cnt_inc;
  logic                     sort_clear;
  logic                     sort_insert;
  logic [SAMPLE_BITS-1:0]   entry_value;
  logic [SAMPLE_BITS-1:0]   median;
  logic [SAMPLE_BITS-1:0]   diff;
  logic                     emit;
  logic [IDX_W-1:0]         rank;

  // Window size in use: zero counts as one, larger values saturate.
  always_comb begin
    if (window_size == '0) begin
      size_eff = CNT_W'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      size_eff = CNT_W'(MAX_WINDOW);
    end else begin
      size_eff = CNT_W'(window_size);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
      deadband    <= DEADBAND_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_SIZE: window_size <= WINDOW_SIZE_W'(cfg_data);
        REG_DEADBAND:    deadband    <= DEADBAND_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Entry moving into logical place cnt: the next entry, or the new sample last.
  assign entry_value = (cnt == size_q - CNT_W'(1)) ? sample_q :
                       (rd_hit ? rd_data : '0);

  // Median decision against the last emitted value.
  assign rank   = IDX_W'(size_q >> 1);
  assign diff   = (median >= last_sent) ? (median - last_sent) : (last_sent - median);
  assign emit   = diff > SAMPLE_BITS'(deadband);

  // Sequencer: next state and control.
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cnt[IDX_W-1:0];
    mem_wdata    = entry_value;
    rd_addr_full = (CNT_W+1)'(cnt) + (CNT_W+1)'(2);
    rd_en        = 1'b0;
    load_out     = 1'b0;
    out_value    = median;
    fill_inc     = 1'b0;
    cnt_clear    = 1'b0;
    cnt_inc      = 1'b0;
    sort_clear   = 1'b0;
    sort_insert  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        rd_addr_full = (CNT_W+1)'(1);
        rd_en        = rd_addr_full < (CNT_W+1)'(MAX_WINDOW);
        cnt_clear    = 1'b1;
        sort_clear   = 1'b1;
        if (accept) begin
          state_next = (fill_count < size_eff) ? ST_WARM : ST_SHIFT;
        end
      end
      ST_WARM: begin
        mem_waddr = fill_count[IDX_W-1:0];
        mem_wdata = sample_q;
        out_value = sample_q;
        if (out_free) begin
          mem_we     = 1'b1;
          load_out   = 1'b1;
          fill_inc   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        mem_we      = 1'b1;
        sort_insert = 1'b1;
        cnt_inc     = 1'b1;
        rd_en       = rd_addr_full < (CNT_W+1)'(MAX_WINDOW);
        if (cnt == size_q - CNT_W'(1)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!emit || out_free) begin
          load_out   = emit;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign rd_addr = rd_addr_full[IDX_W-1:0];

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request and the window size it runs with.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample;
      size_q   <= size_eff;
    end
  end

  // Walk counter over the window.
  always_ff @(posedge clk) begin
    if (rst || cnt_clear) begin
      cnt <= '0;
    end else if (cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Warm-up fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (fill_inc) begin
      fill_count <= fill_count + CNT_W'(1);
    end
  end

  // Window memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_hit      <= 1'b0;
    end else begin
      if (mem_we) begin
        entry_valid[mem_waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= entry_valid[rd_addr];
      end
    end
  end

  // Last emitted value.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sent <= '0;
    end else if (load_out) begin
      last_sent <= out_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      emitted_value <= out_value;
    end
  end

  // Sorted copy of the shifted window.
  smdf_sorter #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sorter (
    .clk        (clk),
    .rst        (rst),
    .clear      (sort_clear),
    .insert     (sort_insert),
    .value      (entry_value),
    .rank       (rank),
    .rank_value (median)
  );

endmodule

`default_nettype wire

### verif/sliding_median_deadband_filter_tb.sv
// Self-checking testbench for the sliding median filter with output deadband.
// Depends on smdf_pkg and the sliding_median_deadband_filter RTL; predicts each
// emitted value in a small scoreboard class and drives the ports with plain tasks.

module sliding_median_deadband_filter_tb;
  import smdf_pkg::*;

  localparam int WIN_DEPTH     = DEF_MAX_WINDOW;
  localparam int SETTLE_CYCLES = 2 * WIN_DEPTH + 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 205;
  localparam int NUM_PHASES    = 8;
  localparam int TIMEOUT_UNITS = 4_000_000;

  // Scoreboard: mirrors the window, fill count and last emitted value, and keeps
  // the filtered values still owed by the block in arrival order.
  class median_scoreboard;
    logic [15:0] window_mem [WIN_DEPTH];
    int unsigned fill_count;
    logic [15:0] last_sent;
    logic [WINDOW_SIZE_W-1:0] window_size_reg;
    logic [DEADBAND_W-1:0] deadband_reg;
    logic [15:0] pending_values [$];
    int samples_seen;
    int values_checked;
    int held_back;
    int errors;

    function new();
      foreach (window_mem[i]) window_mem[i] = '0;
      fill_count = 0;
      last_sent = '0;
      window_size_reg = WINDOW_SIZE_RESET;
      deadband_reg = DEADBAND_RESET;
      samples_seen = 0;
      values_checked = 0;
      held_back = 0;
      errors = 0;
    endfunction

    function void write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOW_SIZE: window_size_reg = data[WINDOW_SIZE_W-1:0];
        REG_DEADBAND:    deadband_reg = data[DEADBAND_W-1:0];
        default:         ;
      endcase
    endfunction

    // A size of zero behaves as one; anything above the memory depth saturates.
    function int unsigned active_size();
      if (window_size_reg == 0) return 1;
      if (window_size_reg > WIN_DEPTH) return WIN_DEPTH;
      return 32'(window_size_reg);
    endfunction

    function void note_sample(logic [15:0] s);
      int unsigned n;
      int j;
      logic [15:0] sorted [WIN_DEPTH];
      logic [15:0] v;
      logic [15:0] med;
      logic [15:0] diff;
      samples_seen++;
      n = active_size();
      // While the window fills, every sample is passed straight through.
      if (fill_count < n) begin
        window_mem[fill_count] = s;
        fill_count++;
        last_sent = s;
        pending_values.push_back(s);
        return;
      end
      // Shift the oldest sample out and the new one in.
      for (int i = 0; i + 1 < n; i++) window_mem[i] = window_mem[i + 1];
      window_mem[n - 1] = s;
      // Ascending insertion sort of the active entries.
      for (int i = 0; i < n; i++) begin
        v = window_mem[i];
        j = i;
        while (j > 0 && sorted[j - 1] > v) begin
          sorted[j] = sorted[j - 1];
          j--;
        end
        sorted[j] = v;
      end
      med = sorted[n / 2];
      diff = (med >= last_sent) ? med - last_sent : last_sent - med;
      // A change equal to the deadband is still held back.
      if (diff > deadband_reg) begin
        last_sent = med;
        pending_values.push_back(med);
      end else begin
        held_back++;
      end
    endfunction

    function void check_emitted(logic [15:0] actual);
      logic [15:0] wanted;
      if (pending_values.size() == 0) begin
        $error("emitted_value: expected no result, actual %0d", actual);
        errors++;
        return;
      end
      wanted = pending_values.pop_front();
      values_checked++;
      if (actual !== wanted) begin
        $error("emitted_value: expected %0d, actual %0d", wanted, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] emitted_value;
  logic cfg_write = 1'b0;
  cfg_reg_t cfg_index = REG_WINDOW_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  median_scoreboard sb;
  logic [15:0] walk_value = 16'h4000;
  int stall_mode = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int rx_cycle = 0;

  sliding_median_deadband_filter DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .emitted_value(emitted_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one sample and hold it until the request is accepted.
  task automatic send_sample(input logic [15:0] s);
    sample <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
  endtask

  // Register writes strobe cfg_write, update the scoreboard, and then drop the strobe again.
  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_register(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every owed value, then let a sample with no result finish its walk.
  task automatic drain_and_settle();
    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly a random walk scaled to the deadband, so that medians land on both
  // sides of it, mixed with full-range values and values at the extremes.
  function automatic logic [15:0] next_sample(input int unsigned db);
    int unsigned pick;
    int target;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      target = int'(walk_value) + int'($urandom_range(0, 2 * db + 4)) - int'(db + 2);
      if (target < 0) target = 0;
      if (target > 65535) target = 65535;
    end else if (pick < 75) begin
      target = $urandom_range(0, 65535);
    end else if (pick < 85) begin
      target = $urandom_range(0, 1) ? 65535 - int'($urandom_range(0, 3)) : $urandom_range(0, 3);
    end else begin
      target = int'(walk_value);
    end
    walk_value = target[15:0];
    return walk_value;
  endfunction

  // Sender works in bursts of random length, mostly separated by random gaps.
  task automatic drive_phase(input int count, input int unsigned db);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_sample(next_sample(db));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: checks each accepted result and stalls on a pattern of its own.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_emitted(emitted_value);
    end
    rx_cycle++;
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (rx_cycle % 7) >= 3;
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Main sequence: directed samples, then random phases over several settings.
  initial begin
    logic [15:0] warm_list [13] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001,
                                   16'h5555, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h0000,
                                   16'hFFFF, 16'hFFFF, 16'h0000};
    logic [15:0] band_list [6] = '{16'h1000, 16'h10FF, 16'h1100, 16'h1000, 16'hFFFF,
                                   16'h0000};
    logic [7:0] phase_size [NUM_PHASES] = '{8'd16, 8'd2, 8'd31, 8'd1, 8'hE7, 8'd4, 8'd16,
                                             8'd3};
    logic [7:0] phase_band [NUM_PHASES] = '{8'd0, 8'd1, 8'd128, 8'd255, 8'd3, 8'd20,
                                             8'd255, 8'd0};
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Warm-up and first medians at the reset settings, field extremes included.
    foreach (warm_list[i]) send_sample(warm_list[i]);
    in_valid <= 1'b0;
    drain_and_settle();

    // A zero size acts as one sample; changes of exactly the deadband are held.
    write_register(REG_WINDOW_SIZE, 8'd0);
    write_register(REG_DEADBAND, 8'd255);
    foreach (band_list[i]) send_sample(band_list[i]);
    in_valid <= 1'b0;
    drain_and_settle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_register(REG_WINDOW_SIZE, phase_size[phase]);
      write_register(REG_DEADBAND, phase_band[phase]);
      stall_mode = phase % 4;
      // One long output hold-off while samples keep coming, to back the block up.
      if (phase == 2) hold_requests++;
      drive_phase(PHASE_ITEMS, phase_band[phase]);
      drain_and_settle();
    end

    $display("Checked %0d filtered values from %0d samples; %0d medians fell inside the deadband.",
             sb.values_checked, sb.samples_seen, sb.held_back);
    $display("Window sizes 0 to 31 and deadbands 0 to 255 were used, with one long output hold-off.");
    if (sb.errors == 0 && sb.pending_values.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_UNITS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
hdl/smdf_pkg.sv
hdl/smdf_sorter.sv
hdl/sliding_median_deadband_filter.sv
verif/sliding_median_deadband_filter_tb.sv
